// ===== sv/wics_pkg.sv =====
// Shared types and constants for the 802.11 information element capability scanner.
// No dependencies.
`timescale 1ns / 1ps

package wics_pkg;

	// element ids
	localparam logic [7:0] ID_RSN    = 8'd48;
	localparam logic [7:0] ID_HT     = 8'd45;
	localparam logic [7:0] ID_VHT    = 8'd191;
	localparam logic [7:0] ID_VENDOR = 8'd221;
	localparam logic [7:0] ID_EXT    = 8'd255;
	localparam logic [7:0] EXT_HE_CAP = 8'd35;

	// vendor OUI plus type for WPA
	localparam logic [7:0] WPA_PREFIX [4] = '{8'h00, 8'h50, 8'hF2, 8'h01};
	localparam logic [2:0] PREFIX_LEN = 3'd4;

	typedef enum logic [1:0] {
		PH_ID  = 2'd0,
		PH_LEN = 2'd1,
		PH_PAY = 2'd2
	} phase_t;

	// one input request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	// capability flags, has_rsn in bit 0
	typedef struct packed {
		logic has_he;
		logic has_vht;
		logic has_ht;
		logic has_wpa;
		logic has_rsn;
	} flags_t;

endpackage

// ===== sv/wlan_ie_capability_scanner.sv =====
// End of list: the input stage loads the result register, which drives m_axis_tvalid.
// Throughput: one request per cycle; the input stalls only while an end-of-list request
// sits in the input stage and the result register is full and not being taken.
// Reset (arst_n low, asynchronous): empties both stages and clears the parse state.
// Depends on wics_pkg and wics_parser.
`timescale 1ns / 1ps

module wlan_ie_capability_scanner import wics_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] has_byte
	input  logic       s_axis_tlast,   // last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] has_rsn [1] has_wpa [2] has_ht [3] has_vht
	                                   // [4] has_he [7:5] zero
);

	logic   valid_s1;
	item_t  item_s1;
	logic   advance;
	flags_t result;
	flags_t flags_q;
	logic   out_valid_q;

	// end-of-list requests need a free result slot; others always drain
	assign advance       = valid_s1 && (!item_s1.last || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{data_byte: s_axis_tdata, has_byte: s_axis_tuser,
				last: s_axis_tlast};
		end
	end

	wics_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last)
			flags_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, flags_q};

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted request lost from input stage");

	a_end_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last |=> out_valid_q)
		else $error("end of list did not produce a result");

	a_blocked_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last && out_valid_q && !m_axis_tready |=> valid_s1)
		else $error("end request dropped while result pending");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("empty input stage not ready");

endmodule

// ===== sv/wics_parser.sv =====
// Element list parse state and per-byte update for the capability scanner.
// Depends on wics_pkg.
`timescale 1ns / 1ps

module wics_parser import wics_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,      // consume item this cycle
	input  item_t  item,
	output flags_t result     // flags including this item, valid when step && item.last
);

	phase_t     phase_q, phase_d;
	logic [7:0] elem_id_q, elem_id_d;
	logic [7:0] left_q, left_d;
	logic [2:0] idx_q, idx_d;
	logic       match_q, match_d;
	logic [7:0] len_q, len_d;
	flags_t     found_q, found_d;

	function automatic flags_t commit_flag(input logic [7:0] id, input logic [7:0] len,
			input logic pm);
		flags_t f;
		f = '0;
		priority if (id == ID_RSN) begin
			f.has_rsn = 1'b1;
		end else if (id == ID_HT) begin
			f.has_ht = 1'b1;
		end else if (id == ID_VHT) begin
			f.has_vht = 1'b1;
		end else if (id == ID_VENDOR && len >= 8'd4 && pm) begin
			f.has_wpa = 1'b1;
		end else if (id == ID_EXT && len >= 8'd1 && pm) begin
			f.has_he = 1'b1;
		end else begin
			f = '0;
		end
		return f;
	endfunction

	logic [7:0] left_dec;
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		elem_id_d = elem_id_q;
		left_d    = left_q;
		idx_d     = idx_q;
		match_d   = match_q;
		len_d     = len_q;
		found_d   = found_q;
		if (step && item.has_byte) begin
			unique case (phase_q)
				PH_LEN: begin
					len_d   = item.data_byte;
					left_d  = item.data_byte;
					idx_d   = '0;
					match_d = 1'b1;
					if (item.data_byte == 8'd0) begin
						found_d = found_q | commit_flag(elem_id_q, 8'd0, 1'b1);
						phase_d = PH_ID;
					end else begin
						phase_d = PH_PAY;
					end
				end
				PH_PAY: begin
					if (elem_id_q == ID_VENDOR && idx_q < PREFIX_LEN) begin
						if (item.data_byte != WPA_PREFIX[idx_q[1:0]])
							match_d = 1'b0;
					end else if (elem_id_q == ID_EXT && idx_q == 3'd0) begin
						if (item.data_byte != EXT_HE_CAP)
							match_d = 1'b0;
					end
					if (idx_q < PREFIX_LEN)
						idx_d = idx_q + 3'd1;
					left_d = left_dec;
					if (left_dec == 8'd0) begin
						found_d = found_q | commit_flag(elem_id_q, len_q, match_d);
						phase_d = PH_ID;
					end
				end
				default: begin
					// unused phase code behaves as id
					elem_id_d = item.data_byte;
					phase_d   = PH_LEN;
				end
			endcase
		end
		result = found_d;
		if (step && item.last) begin
			phase_d   = PH_ID;
			elem_id_d = '0;
			left_d    = '0;
			idx_d     = '0;
			match_d   = 1'b0;
			len_d     = '0;
			found_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID;
			elem_id_q <= '0;
			left_q    <= '0;
			idx_q     <= '0;
			match_q   <= 1'b0;
			len_q     <= '0;
			found_q   <= '0;
		end else begin
			phase_q   <= phase_d;
			elem_id_q <= elem_id_d;
			left_q    <= left_d;
			idx_q     <= idx_d;
			match_q   <= match_d;
			len_q     <= len_d;
			found_q   <= found_d;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last |=> phase_q == PH_ID && found_q == '0)
		else $error("parse state not cleared after end of list");

	a_idx_sat: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= PREFIX_LEN)
		else $error("payload index past saturation");

endmodule
